### design/neighbor_liveness_table_macros.svh
// ----------------------------------------------------------------------------
// Neighbor liveness table assertion macros
// Shared concurrent assertion forms for the table's checker, clocked on clk
// and held off during reset.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_LIVENESS_TABLE_MACROS_SVH
`define NEIGHBOR_LIVENESS_TABLE_MACROS_SVH

// Same-cycle implication.
`define NLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NLT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/nlt_pkg.sv
// ----------------------------------------------------------------------------
// Neighbor liveness table package
// Sizes, entry layout and result codes shared by the table modules.
// ----------------------------------------------------------------------------
package nlt_pkg;

  localparam int NEIGHBORS = 16;
  localparam int IDX_W     = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int CNT_W     = $clog2(NEIGHBORS + 1);

  localparam logic [7:0] TIMEOUT_RESET = 8'd10;

  // input op codes
  localparam logic OP_HELLO = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_HELLO = 2'd0;
  localparam logic [1:0] KIND_DOWN  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // hello outcomes
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_REFRESHED = 2'd1;
  localparam logic [1:0] ST_STALE     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;
  localparam logic [1:0] ST_NONE      = 2'd0;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] seq;
    logic [7:0]  age;
  } entry_t;

endpackage

### design/neighbor_liveness_table.sv
// Order: a hello result loads once the scan meets a matching entry, or from the
// insert state after the scan finds none; a tick sweeps the table, loading down
// items as it goes, then its done result. One item at a time; the sequencer
// reads one slot per cycle through a single read port unless a result stalls;
// in_ready returns the cycle after the last result.
// Reset (rst_n low, synchronous): table empty, timeout 10, no result pending.
// ----------------------------------------------------------------------------
// Neighbor liveness table
// Hello lookup/insert/refresh and tick aging sweep with swap-with-last removal.
// ----------------------------------------------------------------------------
module neighbor_liveness_table (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_timeout_ticks,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_neighbor_addr,
  input  logic [15:0] in_hello_seq,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [31:0] out_result_addr,
  output logic        out_last_of_run
);

  localparam int IDX_W = nlt_pkg::IDX_W;
  localparam int CNT_W = nlt_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HCMP  = 5'b00010,
    S_HINS  = 5'b00100,
    S_TCHK  = 5'b01000,
    S_TDONE = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [7:0]         timeout_r;
  logic [31:0]        lat_addr_r;
  logic [15:0]        lat_seq_r;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_kind_r, out_status_r;
  logic [31:0]        out_addr_r;
  logic               out_last_r;

  logic               out_load;
  logic [1:0]         load_kind, load_status;
  logic [31:0]        load_addr;
  logic               load_last;

  logic               wr_en, rd_en;
  logic [IDX_W-1:0]   wr_idx, rd_idx;
  nlt_pkg::entry_t    wr_entry, rd_entry;

  logic               out_free;
  logic [7:0]         age_inc;
  logic [CNT_W-1:0]   idx_inc;
  logic               is_last;

  nlt_table u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);

  assign out_free = !out_valid_r || out_ready;
  assign age_inc  = (rd_entry.age == 8'hFF) ? 8'hFF : rd_entry.age + 8'd1;
  assign idx_inc  = CNT_W'(idx_r) + CNT_W'(1);
  assign is_last  = (idx_inc == cnt_r);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    rd_en       = 1'b0;
    rd_idx      = idx_r;
    wr_en       = 1'b0;
    wr_idx      = idx_r;
    wr_entry    = '{addr: lat_addr_r, seq: lat_seq_r, age: 8'd0};
    out_load    = 1'b0;
    load_kind   = nlt_pkg::KIND_HELLO;
    load_status = nlt_pkg::ST_NONE;
    load_addr   = lat_addr_r;
    load_last   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt = '0;
          rd_idx  = '0;
          if (in_op == nlt_pkg::OP_HELLO) begin
            if (cnt_r == '0) begin
              state_nxt = S_HINS;
            end else begin
              rd_en     = 1'b1;
              state_nxt = S_HCMP;
            end
          end else begin
            if (cnt_r == '0) begin
              state_nxt = S_TDONE;
            end else begin
              rd_en     = 1'b1;
              state_nxt = S_TCHK;
            end
          end
        end
      end

      S_HCMP: begin
        if (rd_entry.addr == lat_addr_r) begin
          if (out_free) begin
            out_load = 1'b1;
            if (lat_seq_r > rd_entry.seq) begin
              load_status = nlt_pkg::ST_REFRESHED;
              wr_en       = 1'b1;
            end else begin
              load_status = nlt_pkg::ST_STALE;
            end
            state_nxt = S_IDLE;
          end
        end else if (is_last) begin
          state_nxt = S_HINS;
        end else begin
          // advance and prefetch the next slot
          idx_nxt = IDX_W'(idx_inc);
          rd_idx  = IDX_W'(idx_inc);
          rd_en   = 1'b1;
        end
      end

      S_HINS: begin
        if (out_free) begin
          out_load = 1'b1;
          if (cnt_r == CNT_W'(nlt_pkg::NEIGHBORS)) begin
            load_status = nlt_pkg::ST_FULL;
          end else begin
            load_status = nlt_pkg::ST_INSERTED;
            wr_en       = 1'b1;
            wr_idx      = IDX_W'(cnt_r);
            cnt_nxt     = cnt_r + CNT_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end

      S_TCHK: begin
        // every entry seen here at the current slot is still unaged
        if (age_inc > timeout_r) begin
          if (out_free) begin
            out_load    = 1'b1;
            load_kind   = nlt_pkg::KIND_DOWN;
            load_addr   = rd_entry.addr;
            load_last   = 1'b0;
            cnt_nxt     = cnt_r - CNT_W'(1);
            if (is_last) begin
              state_nxt = S_TDONE;
            end else begin
              // pull the last entry into this slot and check it next
              rd_en  = 1'b1;
              rd_idx = IDX_W'(cnt_r - CNT_W'(1));
              wr_en  = 1'b0;
            end
          end
        end else begin
          wr_en    = 1'b1;
          wr_entry = '{addr: rd_entry.addr, seq: rd_entry.seq, age: age_inc};
          if (is_last) begin
            state_nxt = S_TDONE;
          end else begin
            idx_nxt = IDX_W'(idx_inc);
            rd_idx  = IDX_W'(idx_inc);
            rd_en   = 1'b1;
          end
        end
      end

      S_TDONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_kind = nlt_pkg::KIND_DONE;
          load_addr = 32'd0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      timeout_r   <= nlt_pkg::TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_timeout_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lat_addr_r <= in_neighbor_addr;
      lat_seq_r  <= in_hello_seq;
    end
    if (out_load) begin
      out_kind_r   <= load_kind;
      out_status_r <= load_status;
      out_addr_r   <= load_addr;
      out_last_r   <= load_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_result_addr = out_addr_r;
  assign out_last_of_run = out_last_r;

endmodule

### design/nlt_table.sv
// ----------------------------------------------------------------------------
// Neighbor table storage
// One write port and one read port with registered read data; holds address,
// last sequence number and age for every slot.
// ----------------------------------------------------------------------------
module nlt_table (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [nlt_pkg::IDX_W-1:0] wr_idx,
  input  nlt_pkg::entry_t           wr_entry,
  input  logic                      rd_en,
  input  logic [nlt_pkg::IDX_W-1:0] rd_idx,
  output nlt_pkg::entry_t           rd_entry
);

  nlt_pkg::entry_t mem [nlt_pkg::NEIGHBORS];
  nlt_pkg::entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem[rd_idx];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

### design/nlt_chk.sv
// ----------------------------------------------------------------------------
// Neighbor liveness table port checker
// Watches the result channel for consistent item encoding and stall behavior.
// ----------------------------------------------------------------------------
`include "neighbor_liveness_table_macros.svh"

module nlt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [1:0]  out_status,
  input logic [31:0] out_result_addr,
  input logic        out_last_of_run
);

  `NLT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_result_addr) && $stable(out_kind), "result item changed while stalled")

  `NLT_ASSERT_NOW(a_sweep_status, out_valid && out_kind != nlt_pkg::KIND_HELLO, out_status == nlt_pkg::ST_NONE, "sweep item with nonzero status")

  `NLT_ASSERT_NOW(a_hello_last, out_valid && out_kind == nlt_pkg::KIND_HELLO, out_last_of_run, "hello outcome not marked last")

  `NLT_ASSERT_NOW(a_down_not_last, out_valid && out_kind == nlt_pkg::KIND_DOWN, !out_last_of_run, "down item marked last")

  `NLT_ASSERT_NOW(a_done_form, out_valid && out_kind == nlt_pkg::KIND_DONE, out_last_of_run && out_result_addr == 32'd0, "done item malformed")

endmodule

bind neighbor_liveness_table nlt_chk u_nlt_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_status      (out_status),
  .out_result_addr (out_result_addr),
  .out_last_of_run (out_last_of_run)
);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Neighbor liveness table testbench
// Sends hello and tick items through valid/ready with random idling and a long
// output stall. The timeout register is changed between phases, covering 0,
// 1, 254 and 255. Each result is checked field by field against an expected
// item: most directed rows carry it as literal values, and all other items
// take it from an in-bench table predictor.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] addr;
    logic        last;
  } nbr_result_t;

  typedef struct {
    int          cfg;     // timeout to load first, -1 keeps the current one
    logic        op;
    logic [31:0] addr;
    logic [15:0] seq;
    bit          typed;
    logic [1:0]  kind;
    logic [1:0]  status;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_timeout_ticks = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = 1'b0;
  logic [31:0] in_neighbor_addr = 32'd0;
  logic [15:0] in_hello_seq = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [1:0]  out_status;
  logic [31:0] out_result_addr;
  logic        out_last_of_run;

  // predictor state
  nlt_pkg::entry_t nbr_tab[nlt_pkg::NEIGHBORS];
  int          n_entries = 0;
  logic [7:0]  timeout_reg = nlt_pkg::TIMEOUT_RESET;
  nbr_result_t step_results[$];
  nbr_result_t pending_results[$];
  logic [31:0] known_addrs[24];

  int          errors = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  neighbor_liveness_table i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_timeout_ticks (cfg_timeout_ticks),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_neighbor_addr  (in_neighbor_addr),
    .in_hello_seq      (in_hello_seq),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_status        (out_status),
    .out_result_addr   (out_result_addr),
    .out_last_of_run   (out_last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("FAIL neighbor_liveness_table");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    errors++;
  endtask

  // Hello lookup/insert/refresh, or tick aging with swap-with-last removal.
  function automatic void table_step(logic op, logic [31:0] a, logic [15:0] s);
    int hit;
    int k;
    hit = -1;
    step_results.delete();
    if (op == nlt_pkg::OP_HELLO) begin
      for (k = 0; k < n_entries; k++)
        if (hit < 0 && nbr_tab[k].addr == a) hit = k;
      if (hit >= 0) begin
        if (s > nbr_tab[hit].seq) begin
          nbr_tab[hit].seq = s;
          nbr_tab[hit].age = 8'd0;
          step_results.push_back('{nlt_pkg::KIND_HELLO, nlt_pkg::ST_REFRESHED, a, 1'b1});
        end else begin
          step_results.push_back('{nlt_pkg::KIND_HELLO, nlt_pkg::ST_STALE, a, 1'b1});
        end
      end else if (n_entries >= nlt_pkg::NEIGHBORS) begin
        step_results.push_back('{nlt_pkg::KIND_HELLO, nlt_pkg::ST_FULL, a, 1'b1});
      end else begin
        nbr_tab[n_entries] = '{addr: a, seq: s, age: 8'd0};
        n_entries++;
        step_results.push_back('{nlt_pkg::KIND_HELLO, nlt_pkg::ST_INSERTED, a, 1'b1});
      end
    end else begin
      for (k = 0; k < n_entries; k++)
        if (nbr_tab[k].age != 8'hFF) nbr_tab[k].age++;
      k = 0;
      while (k < n_entries) begin
        if (nbr_tab[k].age > timeout_reg) begin
          step_results.push_back('{nlt_pkg::KIND_DOWN, nlt_pkg::ST_NONE,
                                   nbr_tab[k].addr, 1'b0});
          nbr_tab[k] = nbr_tab[n_entries - 1];
          n_entries--;
        end else begin
          k++;
        end
      end
      step_results.push_back('{nlt_pkg::KIND_DONE, nlt_pkg::ST_NONE, 32'd0, 1'b1});
    end
  endfunction

  // Always waits on the clock before checking the queue, so valid is never lowered and raised
  // in the same step.
  task automatic wait_drained();
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_item(logic op, logic [31:0] a, logic [15:0] s,
                           bit typed, logic [1:0] t_kind, logic [1:0] t_status);
    while (idle_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_neighbor_addr <= a;
    in_hello_seq     <= s;
    do @(posedge clk); while (!in_ready);
    table_step(op, a, s);
    if (typed)
      pending_results.push_back('{t_kind, t_status,
                                  (t_kind == nlt_pkg::KIND_DONE) ? 32'd0 : a, 1'b1});
    else
      foreach (step_results[j]) pending_results.push_back(step_results[j]);
  endtask

  task automatic write_timeout(logic [7:0] v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid         <= 1'b1;
    cfg_timeout_ticks <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    timeout_reg = v;
  endtask

  task automatic run_random(int count, int tick_pct, int pool_n, int pause_at);
    logic        op;
    logic [31:0] a;
    logic [15:0] s;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      op = ($urandom_range(99) < tick_pct) ? nlt_pkg::OP_TICK : nlt_pkg::OP_HELLO;
      a  = ($urandom_range(9) == 0) ? $urandom() : known_addrs[$urandom_range(pool_n - 1)];
      case ($urandom_range(7))
        0:       s = 16'h0000;
        1:       s = 16'hFFFF;
        default: s = 16'($urandom());
      endcase
      send_item(op, a, s, 1'b0, nlt_pkg::KIND_HELLO, nlt_pkg::ST_NONE);
    end
  endtask

  // result side: check accepted items, then pick ready for the next cycle
  initial begin
    nbr_result_t want;
    int          hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", out_result_addr, 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_kind !== want.kind)
            report_mismatch("kind", out_kind, want.kind);
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_result_addr !== want.addr)
            report_mismatch("result_addr", out_result_addr, want.addr);
          if (out_last_of_run !== want.last)
            report_mismatch("last_of_run", out_last_of_run, want.last);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 20);
      end
    end
  end

  initial begin
    stim_row_t rows[25];
    rows[0]  = '{-1, nlt_pkg::OP_TICK,  32'hDEAD_BEEF, 16'h5A5A, 1'b1,
                 nlt_pkg::KIND_DONE,  nlt_pkg::ST_NONE};
    rows[1]  = '{-1, nlt_pkg::OP_HELLO, 32'h0000_0000, 16'h0000, 1'b1,
                 nlt_pkg::KIND_HELLO, nlt_pkg::ST_INSERTED};
    rows[2]  = '{-1, nlt_pkg::OP_HELLO, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                 nlt_pkg::KIND_HELLO, nlt_pkg::ST_INSERTED};
    rows[3]  = '{-1, nlt_pkg::OP_HELLO, 32'h0000_0000, 16'h0000, 1'b1,
                 nlt_pkg::KIND_HELLO, nlt_pkg::ST_STALE};
    // wrapped sequence counts as stale
    rows[4]  = '{-1, nlt_pkg::OP_HELLO, 32'hFFFF_FFFF, 16'h0000, 1'b1,
                 nlt_pkg::KIND_HELLO, nlt_pkg::ST_STALE};
    rows[5]  = '{-1, nlt_pkg::OP_HELLO, 32'h0000_0000, 16'h0001, 1'b1,
                 nlt_pkg::KIND_HELLO, nlt_pkg::ST_REFRESHED};
    for (int f = 0; f < 14; f++)
      rows[6 + f] = '{-1, nlt_pkg::OP_HELLO, 32'h0A00_0100 + f, 16'(f * 3 + 1), 1'b1,
                      nlt_pkg::KIND_HELLO, nlt_pkg::ST_INSERTED};
    rows[20] = '{-1, nlt_pkg::OP_HELLO, 32'hC0A8_0001, 16'h1234, 1'b1,
                 nlt_pkg::KIND_HELLO, nlt_pkg::ST_FULL};
    rows[21] = '{-1, nlt_pkg::OP_TICK,  32'h0000_0000, 16'h0000, 1'b0,
                 nlt_pkg::KIND_DONE,  nlt_pkg::ST_NONE};
    // zero timeout drops the whole full table on one tick
    rows[22] = '{0,  nlt_pkg::OP_TICK,  32'hFFFF_FFFF, 16'hFFFF, 1'b0,
                 nlt_pkg::KIND_DONE,  nlt_pkg::ST_NONE};
    rows[23] = '{255, nlt_pkg::OP_HELLO, 32'h1234_5678, 16'h0007, 1'b1,
                 nlt_pkg::KIND_HELLO, nlt_pkg::ST_INSERTED};
    rows[24] = '{-1, nlt_pkg::OP_TICK,  32'h0000_0000, 16'h0000, 1'b0,
                 nlt_pkg::KIND_DONE,  nlt_pkg::ST_NONE};

    foreach (known_addrs[j]) known_addrs[j] = $urandom();
    known_addrs[0] = 32'h0000_0000;
    known_addrs[1] = 32'hFFFF_FFFF;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < 25; r++) begin
      if (rows[r].cfg >= 0) write_timeout(8'(rows[r].cfg));
      send_item(rows[r].op, rows[r].addr, rows[r].seq, rows[r].typed,
                rows[r].kind, rows[r].status);
    end

    // long output stall while items keep coming
    write_timeout(8'd1);
    hold_req = 1'b1;
    run_random(40, 30, 20, -1);

    // no idling on either side
    write_timeout(8'd254);
    idle_on = 1'b0;
    run_random(30, 10, 24, -1);
    idle_on = 1'b1;

    // ages saturate at 255 with nothing removed, then at 254 the saturated ones go
    write_timeout(8'd255);
    run_random(16, 0, 24, -1);
    run_random(256, 100, 24, -1);
    write_timeout(8'd254);
    run_random(12, 25, 24, -1);

    for (int p = 0; p < 4; p++) begin
      write_timeout(8'($urandom_range(2, 12)));
      run_random(10, $urandom_range(20, 40), 24, (p == 1) ? 5 : -1);
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("PASS neighbor_liveness_table");
    else
      $display("FAIL neighbor_liveness_table");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/nlt_pkg.sv
design/nlt_table.sv
design/neighbor_liveness_table.sv
design/nlt_chk.sv
tb/sv/tb_top.sv
